// ----- rtl/core/tw80_pkg.sv -----
// TWINE-80 shared package: widths, register and command codes, controller/datapath
// command structs and the cipher's combinational functions (S-box, Pi, key schedule step).
// No dependencies.
package tw80_pkg;

    localparam int ROUND_KEYS = 36;
    localparam int RK_AW      = $clog2(ROUND_KEYS);
    localparam int BLOCK_W    = 64;
    localparam int RK_W       = 32;
    localparam int KEY_W      = 80;
    localparam int KEY_LOW_W  = 64;
    localparam int KEY_HIGH_W = 16;

    localparam logic [RK_AW-1:0] FIRST_KEY = '0;
    localparam logic [RK_AW-1:0] LAST_KEY  = RK_AW'(ROUND_KEYS - 1);

    localparam logic CMD_ENCRYPT = 1'b0;
    localparam logic CMD_DECRYPT = 1'b1;

    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef struct packed {
        logic             load_data;   // latch block and command of the accepted beat
        logic             load_key;    // copy key registers into the schedule register
        logic             exp_step;    // write one round key, advance the schedule
        logic [RK_AW-1:0] wr_addr;
        logic             rd_en;       // fetch a round key for the next cycle
        logic [RK_AW-1:0] rd_addr;
        logic             round_step;  // full round: mix, then shuffle
        logic             final_step;  // last half round into the output register
    } dp_cmd_t;

    typedef struct packed {
        logic decrypt;
    } dp_status_t;

    function automatic logic [3:0] sbox(input logic [3:0] x);
        logic [3:0] y;
        case (x)
            4'h0: y = 4'hc;
            4'h1: y = 4'h0;
            4'h2: y = 4'hf;
            4'h3: y = 4'ha;
            4'h4: y = 4'h2;
            4'h5: y = 4'hb;
            4'h6: y = 4'h9;
            4'h7: y = 4'h5;
            4'h8: y = 4'h8;
            4'h9: y = 4'h3;
            4'ha: y = 4'hd;
            4'hb: y = 4'h7;
            4'hc: y = 4'h1;
            4'hd: y = 4'he;
            4'he: y = 4'h6;
            default: y = 4'h4;
        endcase
        return y;
    endfunction

    function automatic logic [3:0] perm_fwd(input logic [3:0] h);
        logic [3:0] p;
        case (h)
            4'd0:  p = 4'd5;
            4'd1:  p = 4'd0;
            4'd2:  p = 4'd1;
            4'd3:  p = 4'd4;
            4'd4:  p = 4'd7;
            4'd5:  p = 4'd12;
            4'd6:  p = 4'd3;
            4'd7:  p = 4'd8;
            4'd8:  p = 4'd13;
            4'd9:  p = 4'd6;
            4'd10: p = 4'd9;
            4'd11: p = 4'd2;
            4'd12: p = 4'd15;
            4'd13: p = 4'd10;
            4'd14: p = 4'd11;
            default: p = 4'd14;
        endcase
        return p;
    endfunction

    function automatic logic [3:0] perm_inv(input logic [3:0] h);
        logic [3:0] p;
        case (h)
            4'd0:  p = 4'd1;
            4'd1:  p = 4'd2;
            4'd2:  p = 4'd11;
            4'd3:  p = 4'd6;
            4'd4:  p = 4'd3;
            4'd5:  p = 4'd0;
            4'd6:  p = 4'd9;
            4'd7:  p = 4'd4;
            4'd8:  p = 4'd7;
            4'd9:  p = 4'd10;
            4'd10: p = 4'd13;
            4'd11: p = 4'd14;
            4'd12: p = 4'd5;
            4'd13: p = 4'd8;
            4'd14: p = 4'd15;
            default: p = 4'd12;
        endcase
        return p;
    endfunction

    function automatic logic [5:0] rcon(input logic [RK_AW-1:0] r);
        logic [5:0] c;
        case (r)
            6'd0:  c = 6'h01;
            6'd1:  c = 6'h02;
            6'd2:  c = 6'h04;
            6'd3:  c = 6'h08;
            6'd4:  c = 6'h10;
            6'd5:  c = 6'h20;
            6'd6:  c = 6'h03;
            6'd7:  c = 6'h06;
            6'd8:  c = 6'h0c;
            6'd9:  c = 6'h18;
            6'd10: c = 6'h30;
            6'd11: c = 6'h23;
            6'd12: c = 6'h05;
            6'd13: c = 6'h0a;
            6'd14: c = 6'h14;
            6'd15: c = 6'h28;
            6'd16: c = 6'h13;
            6'd17: c = 6'h26;
            6'd18: c = 6'h0f;
            6'd19: c = 6'h1e;
            6'd20: c = 6'h3c;
            6'd21: c = 6'h3b;
            6'd22: c = 6'h35;
            6'd23: c = 6'h29;
            6'd24: c = 6'h11;
            6'd25: c = 6'h22;
            6'd26: c = 6'h07;
            6'd27: c = 6'h0e;
            6'd28: c = 6'h1c;
            6'd29: c = 6'h38;
            6'd30: c = 6'h33;
            6'd31: c = 6'h25;
            6'd32: c = 6'h09;
            6'd33: c = 6'h12;
            6'd34: c = 6'h24;
            default: c = 6'h00;
        endcase
        return c;
    endfunction

    // Round key = key register nibbles 1,3,4,6,13,14,15,16, low to high.
    function automatic logic [RK_W-1:0] round_key(input logic [KEY_W-1:0] kr);
        return {kr[67:64], kr[63:60], kr[59:56], kr[55:52],
                kr[27:24], kr[19:16], kr[15:12], kr[7:4]};
    endfunction

    function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] kr,
                                                  input logic [RK_AW-1:0] r);
        logic [KEY_W-1:0] v;
        logic [5:0]       rc;
        logic [3:0]       n0;
        v  = kr;
        rc = rcon(r);
        v[7:4]   = kr[7:4]   ^ sbox(kr[3:0]);
        v[19:16] = kr[19:16] ^ sbox(kr[67:64]);
        v[31:28] = kr[31:28] ^ {1'b0, rc[5:3]};
        v[79:76] = kr[79:76] ^ {1'b0, rc[2:0]};
        n0       = v[3:0];
        v[15:0]  = {n0, v[15:4]};
        return {v[15:0], v[KEY_W-1:16]};
    endfunction

    function automatic logic [BLOCK_W-1:0] mix_half(input logic [BLOCK_W-1:0] x,
                                                    input logic [RK_W-1:0] rk);
        logic [BLOCK_W-1:0] y;
        y = x;
        for (int j = 0; j < 8; j++) begin
            y[8*j+4 +: 4] = x[8*j+4 +: 4] ^ sbox(x[8*j +: 4] ^ rk[4*j +: 4]);
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] shuffle(input logic [BLOCK_W-1:0] x,
                                                   input logic dec);
        logic [BLOCK_W-1:0] t;
        logic [3:0]         p;
        t = '0;
        for (int h = 0; h < 16; h++) begin
            p = dec ? perm_inv(4'(h)) : perm_fwd(4'(h));
            t[4*p +: 4] = x[4*h +: 4];
        end
        return t;
    endfunction

endpackage

// ----- rtl/core/tw80_datapath.sv -----
// TWINE-80 datapath: key registers, schedule register, 36 x 32 round-key memory,
// shared round unit and output register. Depends on tw80_pkg.
module tw80_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [tw80_pkg::KEY_LOW_W-1:0]  cfg_data,
    input  logic                            command,
    input  logic [tw80_pkg::BLOCK_W-1:0]    block_in,
    input  tw80_pkg::dp_cmd_t               ctl,
    output tw80_pkg::dp_status_t            status,
    output logic [tw80_pkg::BLOCK_W-1:0]    block_out
);

    logic [tw80_pkg::KEY_LOW_W-1:0]  key_low_reg;
    logic [tw80_pkg::KEY_HIGH_W-1:0] key_high_reg;
    logic [tw80_pkg::KEY_W-1:0]      sched_reg;
    logic [tw80_pkg::BLOCK_W-1:0]    data_reg;
    logic [tw80_pkg::BLOCK_W-1:0]    out_reg;
    logic                            dec_reg;
    logic [tw80_pkg::RK_W-1:0]       rk_reg;
    logic [tw80_pkg::BLOCK_W-1:0]    mixed;

    logic [tw80_pkg::RK_W-1:0] rk_mem [tw80_pkg::ROUND_KEYS];

    assign mixed = tw80_pkg::mix_half(data_reg, rk_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
            sched_reg    <= '0;
            data_reg     <= '0;
            out_reg      <= '0;
            dec_reg      <= tw80_pkg::CMD_ENCRYPT;
        end
        else
        begin
            if (cfg_we && cfg_index == tw80_pkg::REG_KEY_LOW)
                key_low_reg <= cfg_data;
            if (cfg_we && cfg_index == tw80_pkg::REG_KEY_HIGH)
                key_high_reg <= cfg_data[tw80_pkg::KEY_HIGH_W-1:0];

            if (ctl.load_key)
                sched_reg <= {key_high_reg, key_low_reg};
            else if (ctl.exp_step)
                sched_reg <= tw80_pkg::key_step(sched_reg, ctl.wr_addr);

            if (ctl.load_data)
            begin
                data_reg <= block_in;
                dec_reg  <= command;
            end
            else if (ctl.round_step)
                data_reg <= tw80_pkg::shuffle(mixed, dec_reg);

            if (ctl.final_step)
                out_reg <= mixed;
        end
    end

    // Round-key memory: one write port (schedule), one registered read port (rounds).
    always_ff @(posedge clk)
    begin
        if (ctl.exp_step)
            rk_mem[ctl.wr_addr] <= tw80_pkg::round_key(sched_reg);
        if (ctl.rd_en)
            rk_reg <= rk_mem[ctl.rd_addr];
    end

    assign status.decrypt = dec_reg;
    assign block_out      = out_reg;

endmodule

// ----- rtl/core/tw80_ctrl.sv -----
// TWINE-80 controller: sequences key expansion, round-key fetch and the 36 round
// steps, and owns both handshakes. Depends on tw80_pkg.
module tw80_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic                  cfg_we,
    input  tw80_pkg::dp_status_t  status,
    output tw80_pkg::dp_cmd_t     ctl
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXPAND = 2'd1;
    localparam logic [1:0] ST_FETCH  = 2'd2;
    localparam logic [1:0] ST_ROUND  = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [tw80_pkg::RK_AW-1:0] cnt_reg, cnt_next;
    logic                       ready_reg, ready_next;
    logic                       out_valid_reg, out_valid_next;
    logic [tw80_pkg::RK_AW-1:0] cnt_inc;
    logic                       accept;
    logic                       out_free;

    assign cnt_inc  = cnt_reg + 1'b1;
    assign accept   = s_tvalid && (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ready_next     = ready_reg;
        ctl            = '0;
        ctl.wr_addr    = cnt_reg;
        ctl.rd_addr    = tw80_pkg::FIRST_KEY;

        case (state_reg)
            ST_IDLE:
            begin
                if (cfg_we)
                    ready_next = 1'b0;
                if (accept)
                begin
                    ctl.load_data = 1'b1;
                    cnt_next      = '0;
                    if (ready_reg)
                        state_next = ST_FETCH;
                    else
                    begin
                        ctl.load_key = 1'b1;
                        state_next   = ST_EXPAND;
                    end
                end
            end
            ST_EXPAND:
            begin
                ctl.exp_step = 1'b1;
                cnt_next     = cnt_inc;
                if (cnt_reg == tw80_pkg::LAST_KEY)
                begin
                    ready_next = 1'b1;
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                ctl.rd_en   = 1'b1;
                ctl.rd_addr = status.decrypt ? tw80_pkg::LAST_KEY : tw80_pkg::FIRST_KEY;
                cnt_next    = '0;
                state_next  = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (cnt_reg != tw80_pkg::LAST_KEY)
                begin
                    // key for the following round is fetched while this one runs
                    ctl.rd_en      = 1'b1;
                    ctl.rd_addr    = status.decrypt ? (tw80_pkg::LAST_KEY - cnt_inc) : cnt_inc;
                    ctl.round_step = 1'b1;
                    cnt_next       = cnt_inc;
                end
                else if (out_free)
                begin
                    ctl.final_step = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (ctl.final_step)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/core/twine80_block_cipher.sv -----
// TWINE-80 block cipher top level: stream ports, key write port, controller and datapath.
// Depends on tw80_pkg, tw80_ctrl, tw80_datapath.
//
// One 64-bit block per input beat, encrypted (tuser 0) or decrypted (tuser 1) under the
// 80-bit key in key_low/key_high, one result beat per input beat. After acceptance the first
// round key is fetched, then 35 full rounds and the final half round run at one per cycle
// through the single round unit, with each round key read from the 36-entry key memory in
// the cycle before its round. After any key write, the next block first runs the key
// schedule, one round key per cycle into that memory. The result sits in an output
// register; the block takes a new input while it waits, and only stalls in its last round
// if the previous result is still held. Write the key only while no block is in flight.
module twine80_block_cipher (
    input  logic                            clk,
    input  logic                            rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [tw80_pkg::BLOCK_W-1:0]    s_tdata,   // [63:0] block_in
    input  logic                            s_tuser,   // [0] command (0 enc, 1 dec)
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [tw80_pkg::BLOCK_W-1:0]    m_tdata,   // [63:0] block_out
    // key write port: index 0 key_low, index 1 key_high (low 16 bits)
    input  logic                            cfg_we,
    input  logic                            cfg_index,
    input  logic [tw80_pkg::KEY_LOW_W-1:0]  cfg_data
);

    tw80_pkg::dp_cmd_t    ctl;
    tw80_pkg::dp_status_t status;

    tw80_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cfg_we   (cfg_we),
        .status   (status),
        .ctl      (ctl)
    );

    tw80_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .command   (s_tuser),
        .block_in  (s_tdata),
        .ctl       (ctl),
        .status    (status),
        .block_out (m_tdata)
    );

`ifndef SYNTH
    // the last half round never overwrites a result that has not been taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.final_step |-> (!m_tvalid || m_tready))
        else $error("result overwritten before output beat");

    // a finished block shows up as an output beat in the next cycle
    a_result_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.final_step |=> m_tvalid)
        else $error("final round without output beat");

    // key memory is never written and read in the same cycle
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.exp_step && ctl.rd_en))
        else $error("key memory write and read collide");

    // no datapath step while the input side is open
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !(ctl.round_step || ctl.exp_step || ctl.final_step))
        else $error("datapath active while accepting input");
`endif

endmodule

// ----- tb/tb_twine80_block_cipher.sv -----
`timescale 1ns / 100ps
// Self-checking bench for twine80_block_cipher: random and directed TWINE-80 blocks under
// several keys, random idling on both streams, predicted results checked beat by beat.
// Depends on tw80_pkg (widths, command and register codes) and the RTL top level.
module tb_twine80_block_cipher;

    localparam int LIMIT_CYCLES = 500000;
    localparam int HOLD_CYCLES  = 600;     // long receiver hold-off
    localparam int MAX_GAP      = 12;
    localparam int END_DRAIN    = 80;      // final drain before the verdict
    localparam int PHASES       = 10;
    localparam int PHASE_BLOCKS = 150;

    // S-box, nibble i at bits 4i+3..4i
    localparam logic [63:0]  SBOX_NIB = 64'h46E17D3859B2AF0C;
    // destination nibble of source nibble h, encrypt and decrypt shuffles
    localparam logic [63:0]  PERM_ENC = 64'hEBAF296D83C74105;
    localparam logic [63:0]  PERM_DEC = 64'hCF85EDA749036B21;
    // 6-bit round constants, one per byte, round 0 in the low byte
    localparam logic [279:0] RCON_BYTES =
        280'h24120925_33381c0e_07221129_353b3c1e_0f261328_140a0523_30180c06_03201008_040201;

    typedef struct packed {
        logic                         cmd;
        logic [tw80_pkg::BLOCK_W-1:0] blk;
    } block_req_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [tw80_pkg::BLOCK_W-1:0]   s_tdata   = '0;   // [63:0] block_in
    logic                           s_tuser   = 1'b0; // [0] command
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [tw80_pkg::BLOCK_W-1:0]   m_tdata;          // [63:0] block_out
    logic                           cfg_we    = 1'b0;
    logic                           cfg_index = 1'b0;
    logic [tw80_pkg::KEY_LOW_W-1:0] cfg_data  = '0;

    twine80_block_cipher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------------------------
    // Predictor state: key copy, round keys, and whether they match the current key.
    // ---------------------------------------------------------------------------------
    logic [tw80_pkg::KEY_LOW_W-1:0]  key_low_copy   = '0;
    logic [tw80_pkg::KEY_HIGH_W-1:0] key_high_copy  = '0;
    logic [tw80_pkg::RK_W-1:0]       rk_sched [tw80_pkg::ROUND_KEYS];
    logic                            schedule_fresh = 1'b0;

    block_req_t                   blk_pending [$];        // blocks waiting to be sent
    logic [tw80_pkg::BLOCK_W-1:0] block_out_expected [$]; // predicted results, oldest first

    int   errors       = 0;
    int   cycle_count  = 0;
    logic gaps_on      = 1'b1;  // 0 gives stretches with no idling on either side
    int   holds_wanted = 0;     // long hold-offs requested by the stimulus
    int   holds_done   = 0;
    int   send_gap     = 0;
    int   stall_left   = 0;

    function automatic logic [3:0] sub_nib(input logic [3:0] v);
        return SBOX_NIB[4*v +: 4];
    endfunction

    // Build all round keys from the 80-bit key; one schedule step between round keys.
    function automatic void expand_schedule();
        logic [3:0] kr [20];
        logic [3:0] t [20];
        logic [3:0] a;
        logic [5:0] rc;
        for (int i = 0; i < 16; i++)
            kr[i] = key_low_copy[4*i +: 4];
        for (int i = 0; i < 4; i++)
            kr[16+i] = key_high_copy[4*i +: 4];
        for (int r = 0; r < tw80_pkg::ROUND_KEYS; r++)
        begin
            rk_sched[r] = {kr[16], kr[15], kr[14], kr[13], kr[6], kr[4], kr[3], kr[1]};
            if (r < tw80_pkg::ROUND_KEYS - 1)
            begin
                rc     = RCON_BYTES[8*r +: 6];
                kr[1]  = kr[1] ^ sub_nib(kr[0]);
                kr[4]  = kr[4] ^ sub_nib(kr[16]);
                kr[7]  = kr[7] ^ {1'b0, rc[5:3]};
                kr[19] = kr[19] ^ {1'b0, rc[2:0]};
                // rotate the first four nibbles, then rotate the register by four nibbles
                a     = kr[0];
                kr[0] = kr[1];
                kr[1] = kr[2];
                kr[2] = kr[3];
                kr[3] = a;
                for (int i = 0; i < 20; i++)
                    t[i] = kr[(i + 4) % 20];
                for (int i = 0; i < 20; i++)
                    kr[i] = t[i];
            end
        end
        schedule_fresh = 1'b1;
    endfunction

    // odd nibble ^= S(even nibble ^ round-key nibble)
    function automatic logic [63:0] mix_round(input logic [63:0] x, input logic [31:0] rk);
        logic [63:0] y;
        y = x;
        for (int j = 0; j < 8; j++)
            y[8*j+4 +: 4] = x[8*j+4 +: 4] ^ sub_nib(x[8*j +: 4] ^ rk[4*j +: 4]);
        return y;
    endfunction

    function automatic logic [63:0] permute_nibs(input logic [63:0] x, input logic [63:0] dest);
        logic [63:0] y;
        logic [3:0]  p;
        y = '0;
        for (int h = 0; h < 16; h++)
        begin
            p = dest[4*h +: 4];
            y[4*p +: 4] = x[4*h +: 4];
        end
        return y;
    endfunction

    // Expected block_out for one accepted beat; refreshes the round keys after a key write.
    function automatic logic [63:0] twine_crypt(input logic cmd, input logic [63:0] blk);
        logic [63:0] x;
        if (!schedule_fresh)
            expand_schedule();
        x = blk;
        if (cmd == tw80_pkg::CMD_ENCRYPT)
        begin
            for (int r = 0; r < tw80_pkg::ROUND_KEYS - 1; r++)
                x = permute_nibs(mix_round(x, rk_sched[r]), PERM_ENC);
            x = mix_round(x, rk_sched[tw80_pkg::ROUND_KEYS-1]);
        end
        else
        begin
            for (int r = tw80_pkg::ROUND_KEYS - 1; r > 0; r--)
                x = permute_nibs(mix_round(x, rk_sched[r]), PERM_DEC);
            x = mix_round(x, rk_sched[0]);
        end
        return x;
    endfunction

    function automatic int pick_gap();
        return gaps_on ? $urandom_range(0, MAX_GAP) : 0;
    endfunction

    function automatic void push_block(input logic cmd, input logic [63:0] blk);
        block_req_t req;
        req.cmd = cmd;
        req.blk = blk;
        blk_pending.push_back(req);
    endfunction

    // ---------------------------------------------------------------------------------
    // Clock and watchdog
    // ---------------------------------------------------------------------------------
    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Input driver: one block per beat from blk_pending, random gap after each beat.
    // The prediction is taken at acceptance, under the key the block will use.
    // ---------------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_input
        logic       take;
        logic       nxt_valid;
        block_req_t req;
        take      = 1'b0;
        nxt_valid = s_tvalid && !s_tready;  // an unaccepted beat stays on the bus
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                block_out_expected.push_back(twine_crypt(s_tuser, s_tdata));
                send_gap = pick_gap();
                take     = (send_gap == 0);
            end
            else if (!s_tvalid)
            begin
                if (send_gap != 0)
                    send_gap = send_gap - 1;
                else
                    take = 1'b1;
            end
            if (take && blk_pending.size() != 0)
            begin
                req       = blk_pending.pop_front();
                s_tdata   <= req.blk;
                s_tuser   <= req.cmd;
                nxt_valid = 1'b1;
            end
            s_tvalid <= nxt_valid;
        end
    end

    // ---------------------------------------------------------------------------------
    // Output monitor: checks each result beat against the oldest prediction, then draws
    // a stall. A requested hold-off keeps tready low long enough that the block holds a
    // finished result, takes one more block and then backs up its input.
    // ---------------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_output
        logic [63:0] want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (block_out_expected.size() == 0)
                begin
                    $error("block_out: unexpected beat, actual %h", m_tdata);
                    errors = errors + 1;
                end
                else
                begin
                    want = block_out_expected.pop_front();
                    if (m_tdata !== want)
                    begin
                        $error("block_out: expected %h, actual %h", want, m_tdata);
                        errors = errors + 1;
                    end
                end
                stall_left = pick_gap();
            end
            else if (stall_left == 0 && holds_done < holds_wanted)
            begin
                stall_left = HOLD_CYCLES;
                holds_done = holds_done + 1;
            end
            else if (stall_left != 0)
                stall_left = stall_left - 1;
            m_tready <= (stall_left == 0);
        end
    end

    // ---------------------------------------------------------------------------------
    // Stimulus: key writes only while nothing is in flight.
    // ---------------------------------------------------------------------------------
    task automatic write_key_reg(input logic idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == tw80_pkg::REG_KEY_LOW)
            key_low_copy = val;
        else
            key_high_copy = val[tw80_pkg::KEY_HIGH_W-1:0];
        schedule_fresh = 1'b0;  // any key write forces a new schedule
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (blk_pending.size() != 0 || s_tvalid || block_out_expected.size() != 0);
    endtask

    // data extremes and patterns, both directions
    task automatic queue_directed();
        logic cmd;
        @(negedge clk);
        for (int c = 0; c < 2; c++)
        begin
            cmd = c ? tw80_pkg::CMD_DECRYPT : tw80_pkg::CMD_ENCRYPT;
            push_block(cmd, 64'h0000_0000_0000_0000);
            push_block(cmd, 64'hFFFF_FFFF_FFFF_FFFF);
            push_block(cmd, 64'h5555_5555_5555_5555);
            push_block(cmd, 64'hAAAA_AAAA_AAAA_AAAA);
            push_block(cmd, 64'h0123_4567_89AB_CDEF);
            push_block(cmd, 64'hFEDC_BA98_7654_3210);
        end
    endtask

    initial
    begin : stimulus
        logic [63:0] klo;
        logic [63:0] khi;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset key (all zero), first block also runs the first schedule
        queue_directed();
        wait_drained();

        // all-ones key
        write_key_reg(tw80_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_key_reg(tw80_pkg::REG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        queue_directed();
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            klo = {$urandom, $urandom};
            khi = {$urandom, $urandom};  // upper bits are don't-care for key_high
            case (p)
                1: write_key_reg(tw80_pkg::REG_KEY_HIGH, khi);  // one register alone
                2: write_key_reg(tw80_pkg::REG_KEY_LOW, klo);
                3:
                begin
                    write_key_reg(tw80_pkg::REG_KEY_LOW, 64'h0);
                    write_key_reg(tw80_pkg::REG_KEY_HIGH, 64'hFFFF);
                end
                4:
                begin
                    write_key_reg(tw80_pkg::REG_KEY_HIGH, 64'h0);
                    write_key_reg(tw80_pkg::REG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
                end
                default:
                begin
                    write_key_reg(tw80_pkg::REG_KEY_LOW, klo);
                    write_key_reg(tw80_pkg::REG_KEY_HIGH, khi);
                end
            endcase
            @(negedge clk);
            gaps_on = (p % 3 != 2);
            if (p == 5)
                holds_wanted = holds_wanted + 1;  // sender runs flat out meanwhile
            for (int n = 0; n < PHASE_BLOCKS; n++)
                push_block($urandom_range(0, 1) ? tw80_pkg::CMD_DECRYPT : tw80_pkg::CMD_ENCRYPT,
                           {$urandom, $urandom});
            wait_drained();
        end

        repeat (END_DRAIN) @(posedge clk);
        if (errors == 0 && block_out_expected.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
